// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define GHA_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Antecedent implies consequent at the same edge, outside reset.
`define GHA_ASSERT_IMPLY(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

// Antecedent implies consequent at the next edge, outside reset.
`define GHA_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/gha_pkg.sv =====
// Shared types and constants of the generational handle allocator.
package gha_pkg;

   localparam int CAPACITY = 1024;
   localparam int IDX_W    = 10;
   localparam int CNT_W    = 11;
   localparam int VER_W    = 16;
   localparam int PAY_W    = 16;
   localparam int ST_W     = 2;

   typedef enum logic [1:0] {
      CMD_ALLOC    = 2'd0,
      CMD_CHANGE   = 2'd1,
      CMD_FREE     = 2'd2,
      CMD_FREE_ALL = 2'd3
   } gha_cmd_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_STALE    = 2'd2,
      ST_RESERVED = 2'd3
   } gha_status_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic execute;
      logic sweep_run;
   } gha_ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic need_sweep;
      logic sweep_last;
   } gha_stat_type;

endpackage

// ===== rtl/core/gha_ctrl.sv =====
// Controller state machine of the handle allocator.
module gha_ctrl
   import gha_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         rsp_stall,
   input  gha_stat_type stat,
   output gha_ctl_type  ctl,
   output logic         req_stall,
   output logic         rsp_valid
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SWEEP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      room;

   assign room = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      ctl.accept    = (state_ff == S_IDLE) && req_valid && room;
      ctl.execute   = (state_ff == S_EXEC);
      ctl.sweep_run = (state_ff == S_SWEEP);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctl.accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = stat.need_sweep ? S_SWEEP : S_IDLE;
         end
         S_SWEEP: begin
            if (stat.sweep_last) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // reset starts with the table clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = !((state_ff == S_IDLE) && room);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/gha_datapath.sv =====
// Slot tables, free list registers and result register of the allocator.
module gha_datapath
   import gha_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  gha_ctl_type       ctl,
   input  logic [1:0]        req_cmd,
   input  logic [IDX_W-1:0]  req_handle_slot,
   input  logic [VER_W-1:0]  req_handle_version,
   input  logic [PAY_W-1:0]  req_pool_index,
   input  logic [PAY_W-1:0]  req_spawner_id,
   output gha_stat_type      stat,
   output logic [IDX_W-1:0]  rsp_out_slot,
   output logic [VER_W-1:0]  rsp_out_version,
   output logic [ST_W-1:0]   rsp_status
);

   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [PAY_W-1:0] PAY_RSV  = '1;

   // memories: {occupied, generation}, free links, payload
   logic [VER_W:0]       slot_mem [CAPACITY];
   logic [IDX_W-1:0]     link_mem [CAPACITY];
   logic [2*PAY_W-1:0]   pay_mem  [CAPACITY];

   // captured item
   gha_cmd_type          cmd_ff;
   logic [IDX_W-1:0]     slot_ff;
   logic [VER_W-1:0]     ver_ff;
   logic [PAY_W-1:0]     pool_ff;
   logic [PAY_W-1:0]     spawn_ff;

   logic [VER_W:0]       slot_rd_ff;
   logic [IDX_W-1:0]     link_rd_ff;

   logic [IDX_W-1:0]     free_head_ff;
   logic [IDX_W-1:0]     free_head_in;
   logic [CNT_W-1:0]     free_count_ff;
   logic [CNT_W-1:0]     free_count_in;

   logic [CNT_W-1:0]     sweep_cnt_ff;
   logic                 bump_ff;
   logic                 wr_vld_ff;
   logic [IDX_W-1:0]     wr_addr_ff;

   logic [IDX_W-1:0]     out_slot_ff;
   logic [IDX_W-1:0]     out_slot_in;
   logic [VER_W-1:0]     out_ver_ff;
   logic [VER_W-1:0]     out_ver_in;
   gha_status_type       status_ff;
   gha_status_type       status_in;

   logic                 slot_re;
   logic [IDX_W-1:0]     slot_ra;
   logic                 slot_we;
   logic [IDX_W-1:0]     slot_wa;
   logic [VER_W:0]       slot_wd;
   logic                 link_we;
   logic [IDX_W-1:0]     link_wa;
   logic [IDX_W-1:0]     link_wd;
   logic                 pay_we;
   logic [IDX_W-1:0]     pay_wa;

   logic                 reserved;
   logic                 handle_ok;
   logic                 sweep_rd;
   logic [VER_W-1:0]     swept_gen;

   assign reserved  = (pool_ff == PAY_RSV) || (spawn_ff == PAY_RSV);
   assign handle_ok = ({1'b0, slot_ff} < CAP_CNT) && slot_rd_ff[VER_W]
                      && (slot_rd_ff[VER_W-1:0] == ver_ff);
   assign sweep_rd  = ctl.sweep_run && (sweep_cnt_ff < CAP_CNT);
   assign swept_gen = bump_ff ? (slot_rd_ff[VER_W-1:0] + 1'b1) : '0;

   assign stat.need_sweep = (cmd_ff == CMD_FREE_ALL) && (free_count_ff != CAP_CNT);
   assign stat.sweep_last = (sweep_cnt_ff == CAP_CNT);

   // read address: on accept, alloc looks at the head, others at the handle; else the sweep counter
   always_comb begin
      slot_re = ctl.accept || sweep_rd;
      slot_ra = sweep_cnt_ff[IDX_W-1:0];
      if (ctl.accept) begin
         slot_ra = (gha_cmd_type'(req_cmd) == CMD_ALLOC) ? free_head_ff : req_handle_slot;
      end
   end

   always_comb begin
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      out_slot_in   = slot_ff;
      out_ver_in    = ver_ff;
      status_in     = ST_OK;
      slot_we       = 1'b0;
      slot_wa       = slot_ff;
      slot_wd       = {1'b0, ver_ff + 1'b1};
      link_we       = 1'b0;
      link_wa       = slot_ff;
      link_wd       = free_head_ff;
      pay_we        = 1'b0;
      pay_wa        = slot_ff;

      if (ctl.execute) begin
         case (cmd_ff)
            CMD_ALLOC: begin
               out_slot_in = '0;
               out_ver_in  = '0;
               if (reserved) begin
                  status_in = ST_RESERVED;
               end else if (free_count_ff == '0) begin
                  status_in = ST_FULL;
               end else begin
                  slot_we       = 1'b1;
                  slot_wa       = free_head_ff;
                  slot_wd       = {1'b1, slot_rd_ff[VER_W-1:0]};
                  pay_we        = 1'b1;
                  pay_wa        = free_head_ff;
                  free_head_in  = link_rd_ff;
                  free_count_in = free_count_ff - 1'b1;
                  out_slot_in   = free_head_ff;
                  out_ver_in    = slot_rd_ff[VER_W-1:0];
               end
            end
            CMD_CHANGE: begin
               if (reserved) begin
                  status_in = ST_RESERVED;
               end else if (!handle_ok) begin
                  status_in = ST_STALE;
               end else begin
                  pay_we = 1'b1;
               end
            end
            CMD_FREE: begin
               if (!handle_ok) begin
                  status_in = ST_STALE;
               end else begin
                  slot_we       = 1'b1;
                  link_we       = 1'b1;
                  free_head_in  = slot_ff;
                  free_count_in = free_count_ff + 1'b1;
               end
            end
            CMD_FREE_ALL: begin
               out_slot_in = '0;
               out_ver_in  = '0;
               if (stat.need_sweep) begin
                  free_head_in  = '0;
                  free_count_in = CAP_CNT;
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end else if (wr_vld_ff) begin
         // sweep write stage: relink and clear (or bump) one entry
         slot_we = 1'b1;
         slot_wa = wr_addr_ff;
         slot_wd = {1'b0, swept_gen};
         link_we = 1'b1;
         link_wa = wr_addr_ff;
         link_wd = (wr_addr_ff == LAST_IDX) ? '0 : (wr_addr_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_wa] <= slot_wd;
      if (slot_re) slot_rd_ff <= slot_mem[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_wa] <= link_wd;
      if (ctl.accept) link_rd_ff <= link_mem[free_head_ff];
   end

   always_ff @(posedge clock) begin
      if (pay_we) pay_mem[pay_wa] <= {pool_ff, spawn_ff};
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff   <= gha_cmd_type'(req_cmd);
         slot_ff  <= req_handle_slot;
         ver_ff   <= req_handle_version;
         pool_ff  <= req_pool_index;
         spawn_ff <= req_spawner_id;
      end
      if (ctl.execute) begin
         out_slot_ff <= out_slot_in;
         out_ver_ff  <= out_ver_in;
         status_ff   <= status_in;
      end
      if (sweep_rd) begin
         wr_addr_ff <= sweep_cnt_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= '0;
         free_count_ff <= CAP_CNT;
         sweep_cnt_ff  <= '0;
         bump_ff       <= 1'b0;
         wr_vld_ff     <= 1'b0;
      end else begin
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         if (ctl.execute && stat.need_sweep) begin
            sweep_cnt_ff <= '0;
            bump_ff      <= 1'b1;
            wr_vld_ff    <= 1'b0;
         end else if (ctl.sweep_run) begin
            wr_vld_ff <= sweep_rd;
            if (sweep_rd) sweep_cnt_ff <= sweep_cnt_ff + 1'b1;
         end else begin
            wr_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_out_slot    = out_slot_ff;
   assign rsp_out_version = out_ver_ff;
   assign rsp_status      = status_ff;

endmodule

// ===== rtl/core/generational_handle_allocator_core.sv =====
// Top level of the generational handle allocator: controller, datapath, checks.
//
// Hands out handles (slot + generation) from a 1024-slot table kept as a free list.
// req_ channel: one command item (alloc, change payload, free handle, free all).
// rsp_ channel: exactly one result item per command: slot, version, status.
// Both channels: item moves on a clock edge with valid high and stall low.
// Per command: the accepting edge reads the slot entry (and the head link); the
//   next cycle checks and writes, and rsp_valid rises at the edge that ends it.
// A new command is taken only after the previous one has left the execute state,
//   set by the single read-then-write of the slot memory per command.
// Free all with any slot in use walks the whole table after its result is
//   produced, one entry a cycle through a read/bump/write pipe.
// Reset: synchronous, active high. Afterwards the block runs a clearing pass
//   over the slot and link memories with req_stall high.
// Receiver stall: the result waits in the output register and req_stall stays
//   high until it leaves; a new request can be taken at the edge it leaves.
// Payload memory is write-only state: no result depends on it.
module generational_handle_allocator_core
   import gha_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic [IDX_W-1:0]  req_handle_slot,
   input  logic [VER_W-1:0]  req_handle_version,
   input  logic [PAY_W-1:0]  req_pool_index,
   input  logic [PAY_W-1:0]  req_spawner_id,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [IDX_W-1:0]  rsp_out_slot,
   output logic [VER_W-1:0]  rsp_out_version,
   output logic [ST_W-1:0]   rsp_status
);

`include "assert_macros.svh"

   gha_ctl_type  ctl;
   gha_stat_type stat;
   logic         req_take;

   assign req_take = req_valid && !req_stall;

   gha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .ctl       (ctl),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   gha_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .req_cmd            (req_cmd),
      .req_handle_slot    (req_handle_slot),
      .req_handle_version (req_handle_version),
      .req_pool_index     (req_pool_index),
      .req_spawner_id     (req_spawner_id),
      .stat               (stat),
      .rsp_out_slot       (rsp_out_slot),
      .rsp_out_version    (rsp_out_version),
      .rsp_status         (rsp_status)
   );

   // one item in flight: an accepted item blocks the next cycle's accept
   `GHA_ASSERT_NEXT(a_one_in_flight, req_take, req_stall, "back-to-back accept")

   // a fresh result only ever follows an earlier accept through the execute state
   `GHA_ASSERT_IMPLY(a_rsp_follows_req, $rose(rsp_valid), $past(req_take, 2), "orphan result")

   // table sweeps never overlap with accepting items
   `GHA_ASSERT_ALWAYS(a_sweep_blocks, !ctl.sweep_run || req_stall, "accept during sweep")

endmodule
